// File: rtl/dpl_pkg.sv
// dpl_pkg: shared types and constants of the dbscan point labeler
// command and status bundles between controller and datapath
// no dependencies
`default_nettype none

package dpl_pkg;

    localparam int LABEL_W  = 7;
    localparam int RADIUS_W = 16;
    localparam int MINNB_W  = 7;
    localparam int FCOUNT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LABEL_W-1:0] LABEL_NOISE = 7'h7F;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINNB  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FCOUNT = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd128;
    localparam logic [MINNB_W-1:0]  MINNB_RST  = 7'd2;
    localparam logic [FCOUNT_W-1:0] FCOUNT_RST = 5'd16;

    typedef struct packed {
        logic load;
        logic fill_step;
        logic clu_start;
        logic i_inc;
        logic core_from_i;
        logic core_from_q;
        logic j_clear;
        logic j_inc;
        logic pair_start;
        logic cnt_inc;
        logic mark_noise;
        logic mark_cluster;
        logic mark_sel_q;
        logic seed_i;
        logic push_j;
        logic q_take;
        logic cluster_inc;
        logic out_load;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic set_last;
        logic fill_needed;
        logic fill_last;
        logic i_end;
        logic i_visited;
        logic j_end;
        logic j_skip;
        logic pair_done;
        logic neighbor;
        logic is_core;
        logic q_empty;
        logic q_visited;
        logic q_noise;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/dbscan_point_labeler.sv
// dbscan_point_labeler: one feature request per cycle while loading; the request flagged
// last closes the set, a short final point is zero-filled, then clustering runs core
// tests and expansion scans on the single distance pipeline, which reads two features
// per cycle; labels leave one at a time, each once the last was taken. asynchronous
// active-low reset clears all control state and loads the config registers with their
// defaults; no memory clearing pass is needed
`default_nettype none

module dbscan_point_labeler #(
    parameter int MAX_POINTS   = 64,
    parameter int MAX_FEATURES = 16,
    parameter int FEATURE_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [FEATURE_BITS-1:0]  feature_value,
    input  wire logic                            last_of_set,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [dpl_pkg::LABEL_W-1:0]   cluster_label,
    output logic                                 last_label,
    output logic                                 points_dropped,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dpl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dpl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dpl_pkg::cmd_t    cmd;
    dpl_pkg::status_t st;

    dpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    dpl_datapath #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_FEATURES (MAX_FEATURES),
        .FEATURE_BITS (FEATURE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .feature_value  (feature_value),
        .last_of_set    (last_of_set),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .cluster_label  (cluster_label),
        .last_label     (last_label),
        .points_dropped (points_dropped),
        .cmd            (cmd),
        .st             (st)
    );

endmodule

`default_nettype wire

// File: rtl/dpl_ram.sv
// dpl_ram: generic memory, one write port and two registered read ports
// no dependencies
`default_nettype none

module dpl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic      [WIDTH-1:0]                      rdata_a,
    output logic      [WIDTH-1:0]                      rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// File: rtl/dpl_dist.sv
// dpl_dist: squared euclidean distance of two stored points against a limit
// streams one feature pair per cycle from the point memory
`default_nettype none

module dpl_dist #(
    parameter int MAX_POINTS   = 64,
    parameter int MAX_FEATURES = 16,
    parameter int FEATURE_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [$clog2(MAX_POINTS)-1:0]   a_pt,
    input  wire logic [$clog2(MAX_POINTS)-1:0]   b_pt,
    input  wire logic [(MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1):0] nf,
    input  wire logic [31:0]                     lim,
    output logic [$clog2(MAX_POINTS) + (MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1)-1:0] addr_a,
    output logic [$clog2(MAX_POINTS) + (MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1)-1:0] addr_b,
    input  wire logic [FEATURE_BITS-1:0]         rdata_a,
    input  wire logic [FEATURE_BITS-1:0]         rdata_b,
    output logic                                 done,
    output logic                                 neighbor
);

    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int NW = FW + 1;
    localparam int DW = FEATURE_BITS + 1;
    localparam int SW = 2 * DW;
    localparam int AW = SW + FW;
    localparam int CW = (AW > 32) ? AW : 32;

    logic          busy_reg;
    logic [FW-1:0] f_reg;
    logic          s1_v_reg, s1_last_reg, s2_v_reg, s2_last_reg;
    logic [SW-1:0] sq_reg;
    logic [AW-1:0] acc_reg;
    logic          done_reg, nb_reg;

    logic          iss_last;
    logic signed [DW-1:0] diff;
    logic [DW-1:0] mag;
    logic [AW-1:0] acc_next;

    assign iss_last = (NW'(f_reg) + NW'(1)) == nf;
    assign addr_a   = {a_pt, f_reg};
    assign addr_b   = {b_pt, f_reg};

    assign diff     = DW'($signed(rdata_a)) - DW'($signed(rdata_b));
    assign mag      = diff[DW-1] ? DW'(-diff) : DW'(diff);
    assign acc_next = acc_reg + AW'(sq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            f_reg       <= '0;
            s1_v_reg    <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_v_reg    <= 1'b0;
            s2_last_reg <= 1'b0;
            done_reg    <= 1'b0;
            nb_reg      <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                f_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (iss_last)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    f_reg <= f_reg + FW'(1);
                end
            end
            s1_v_reg    <= busy_reg;
            s1_last_reg <= busy_reg & iss_last;
            s2_v_reg    <= s1_v_reg;
            s2_last_reg <= s1_last_reg;
            done_reg    <= s2_v_reg & s2_last_reg;
            if (s2_v_reg && s2_last_reg)
            begin
                nb_reg <= CW'(acc_next) <= CW'(lim);
            end
        end
    end

    // datapath registers of the pair pipeline
    always_ff @(posedge clk)
    begin
        sq_reg <= SW'(mag) * SW'(mag);
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (s2_v_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done     = done_reg;
    assign neighbor = nb_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (!busy_reg && !s1_v_reg && !s2_v_reg))
        else $error("pair started while distance pipeline busy");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(s2_last_reg))
        else $error("done without last feature pair");

    a_busy_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg)
        else $error("done while still issuing features");

endmodule

`default_nettype wire

// File: rtl/dpl_datapath.sv
// dpl_datapath: config registers, point loader, cluster bookkeeping and result register
// uses dpl_pkg, dpl_ram and dpl_dist
`default_nettype none

module dpl_datapath #(
    parameter int MAX_POINTS   = 64,
    parameter int MAX_FEATURES = 16,
    parameter int FEATURE_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dpl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dpl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic signed [FEATURE_BITS-1:0]  feature_value,
    input  wire logic                            last_of_set,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic signed [dpl_pkg::LABEL_W-1:0]   cluster_label,
    output logic                                 last_label,
    output logic                                 points_dropped,
    input  wire dpl_pkg::cmd_t                   cmd,
    output dpl_pkg::status_t                     st
);

    localparam int PW = $clog2(MAX_POINTS);
    localparam int IW = PW + 1;
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int NW = FW + 1;
    localparam int MW = PW + FW;
    localparam int LW = dpl_pkg::LABEL_W;

    logic [dpl_pkg::RADIUS_W-1:0] radius_reg;
    logic [dpl_pkg::MINNB_W-1:0]  minnb_reg;
    logic [dpl_pkg::FCOUNT_W-1:0] fcount_reg;
    logic [31:0]                  lim_reg;

    logic [IW-1:0] n_reg;
    logic [FW-1:0] fp_reg;
    logic          ovf_reg;
    logic [PW-1:0] fill_pt_reg;
    logic [FW-1:0] fill_pos_reg;

    logic [IW-1:0] i_reg, j_reg, cnt_reg, head_reg, tail_reg;
    logic [PW-1:0] p_reg, q_reg;
    logic [LW-1:0] cluster_reg;
    logic [MAX_POINTS-1:0] visited_reg, noise_reg, queued_reg;

    logic          out_valid_reg, out_last_reg, out_drop_reg;
    logic [LW-1:0] out_label_reg;

    logic [NW-1:0] nf;
    logic [NW-1:0] fp_inc;
    logic          room, closes;
    logic [PW-1:0] i_idx, j_idx, lbl_addr;

    logic          pt_we;
    logic [MW-1:0] pt_waddr, pt_raddr_a, pt_raddr_b;
    logic [FEATURE_BITS-1:0] pt_wdata, pt_rdata_a, pt_rdata_b;
    logic [LW-1:0] lbl_wdata, lbl_rdata;
    logic [PW-1:0] qu_rdata;
    logic          dist_done, dist_nb;

    always_comb
    begin
        if (fcount_reg == '0)
        begin
            nf = NW'(1);
        end
        else if (7'(fcount_reg) > 7'(MAX_FEATURES))
        begin
            nf = NW'(MAX_FEATURES);
        end
        else
        begin
            nf = NW'(fcount_reg);
        end
    end

    assign fp_inc   = NW'(fp_reg) + NW'(1);
    assign room     = n_reg != IW'(MAX_POINTS);
    assign closes   = last_of_set | (fp_inc >= nf);
    assign i_idx    = i_reg[PW-1:0];
    assign j_idx    = j_reg[PW-1:0];
    assign lbl_addr = cmd.mark_sel_q ? q_reg : i_idx;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= dpl_pkg::RADIUS_RST;
            minnb_reg  <= dpl_pkg::MINNB_RST;
            fcount_reg <= dpl_pkg::FCOUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dpl_pkg::CFG_RADIUS: radius_reg <= cfg_data[dpl_pkg::RADIUS_W-1:0];
                dpl_pkg::CFG_MINNB:  minnb_reg  <= cfg_data[dpl_pkg::MINNB_W-1:0];
                dpl_pkg::CFG_FCOUNT: fcount_reg <= cfg_data[dpl_pkg::FCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg     <= 32'(radius_reg) * 32'(radius_reg);
        fill_pt_reg <= cmd.load ? n_reg[PW-1:0] : fill_pt_reg;
    end

    // loader and clustering control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg        <= '0;
            fp_reg       <= '0;
            ovf_reg      <= 1'b0;
            fill_pos_reg <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            cnt_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            p_reg        <= '0;
            q_reg        <= '0;
            cluster_reg  <= '0;
            visited_reg  <= '0;
            noise_reg    <= '0;
            queued_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (!room)
                begin
                    ovf_reg <= 1'b1;
                end
                if (closes)
                begin
                    if (room)
                    begin
                        n_reg <= n_reg + IW'(1);
                    end
                    fp_reg <= '0;
                end
                else
                begin
                    fp_reg <= fp_inc[FW-1:0];
                end
                fill_pos_reg <= fp_inc[FW-1:0];
            end
            if (cmd.fill_step)
            begin
                fill_pos_reg <= fill_pos_reg + FW'(1);
            end
            if (cmd.finish)
            begin
                n_reg   <= '0;
                fp_reg  <= '0;
                ovf_reg <= 1'b0;
            end

            if (cmd.clu_start)
            begin
                i_reg       <= '0;
                cluster_reg <= '0;
                visited_reg <= '0;
                noise_reg   <= '0;
            end
            if (cmd.i_inc)
            begin
                i_reg <= i_reg + IW'(1);
            end
            if (cmd.core_from_i || cmd.core_from_q)
            begin
                p_reg   <= cmd.core_from_q ? q_reg : i_idx;
                cnt_reg <= '0;
                j_reg   <= '0;
            end
            if (cmd.j_clear)
            begin
                j_reg <= '0;
            end
            if (cmd.j_inc)
            begin
                j_reg <= j_reg + IW'(1);
            end
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + IW'(1);
            end
            if (cmd.mark_noise)
            begin
                visited_reg[i_idx] <= 1'b1;
                noise_reg[i_idx]   <= 1'b1;
            end
            if (cmd.mark_cluster)
            begin
                visited_reg[lbl_addr] <= 1'b1;
                noise_reg[lbl_addr]   <= 1'b0;
            end
            if (cmd.seed_i)
            begin
                queued_reg        <= {{(MAX_POINTS-1){1'b0}}, 1'b1} << i_idx;
                head_reg          <= '0;
                tail_reg          <= '0;
            end
            if (cmd.push_j)
            begin
                queued_reg[j_idx] <= 1'b1;
                tail_reg          <= tail_reg + IW'(1);
            end
            if (cmd.q_take)
            begin
                q_reg    <= qu_rdata;
                head_reg <= head_reg + IW'(1);
            end
            if (cmd.cluster_inc)
            begin
                cluster_reg <= cluster_reg + LW'(1);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_label_reg <= noise_reg[j_idx] ? dpl_pkg::LABEL_NOISE : lbl_rdata;
            out_last_reg  <= (j_reg + IW'(1)) == n_reg;
            out_drop_reg  <= ovf_reg;
        end
    end

    // point memory
    assign pt_we    = cmd.load ? room : cmd.fill_step;
    assign pt_waddr = cmd.load ? {n_reg[PW-1:0], fp_reg} : {fill_pt_reg, fill_pos_reg};
    assign pt_wdata = cmd.load ? feature_value : '0;

    dpl_ram #(
        .WIDTH (FEATURE_BITS),
        .DEPTH (MAX_POINTS << FW)
    ) u_point_ram (
        .clk     (clk),
        .we      (pt_we),
        .waddr   (pt_waddr),
        .wdata   (pt_wdata),
        .raddr_a (pt_raddr_a),
        .raddr_b (pt_raddr_b),
        .rdata_a (pt_rdata_a),
        .rdata_b (pt_rdata_b)
    );

    dpl_dist #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_FEATURES (MAX_FEATURES),
        .FEATURE_BITS (FEATURE_BITS)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.pair_start),
        .a_pt     (p_reg),
        .b_pt     (j_idx),
        .nf       (nf),
        .lim      (lim_reg),
        .addr_a   (pt_raddr_a),
        .addr_b   (pt_raddr_b),
        .rdata_a  (pt_rdata_a),
        .rdata_b  (pt_rdata_b),
        .done     (dist_done),
        .neighbor (dist_nb)
    );

    // label memory, read by the result sweep
    assign lbl_wdata = cmd.mark_noise ? dpl_pkg::LABEL_NOISE : cluster_reg;

    dpl_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_POINTS)
    ) u_label_ram (
        .clk     (clk),
        .we      (cmd.mark_noise | cmd.mark_cluster),
        .waddr   (cmd.mark_noise ? i_idx : lbl_addr),
        .wdata   (lbl_wdata),
        .raddr_a (j_idx),
        .raddr_b (j_idx),
        .rdata_a (lbl_rdata),
        .rdata_b ()
    );

    // seed queue
    dpl_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_seed_ram (
        .clk     (clk),
        .we      (cmd.push_j),
        .waddr   (tail_reg[PW-1:0]),
        .wdata   (j_idx),
        .raddr_a (head_reg[PW-1:0]),
        .raddr_b (head_reg[PW-1:0]),
        .rdata_a (qu_rdata),
        .rdata_b ()
    );

    always_comb
    begin
        st.set_last    = last_of_set;
        st.fill_needed = room & last_of_set & (fp_inc < nf);
        st.fill_last   = (NW'(fill_pos_reg) + NW'(1)) >= nf;
        st.i_end       = i_reg == n_reg;
        st.i_visited   = visited_reg[i_idx];
        st.j_end       = j_reg == n_reg;
        st.j_skip      = queued_reg[j_idx] | (visited_reg[j_idx] & ~noise_reg[j_idx]);
        st.pair_done   = dist_done;
        st.neighbor    = dist_nb;
        st.is_core     = dpl_pkg::MINNB_W'(cnt_reg) >= minnb_reg;
        st.q_empty     = head_reg == tail_reg;
        st.q_visited   = visited_reg[q_reg];
        st.q_noise     = noise_reg[q_reg];
        st.out_busy    = out_valid_reg;
    end

    assign out_valid      = out_valid_reg;
    assign cluster_label  = out_label_reg;
    assign last_label     = out_last_reg;
    assign points_dropped = out_drop_reg;

    a_push_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_j |-> !queued_reg[j_idx])
        else $error("point pushed twice into seed queue");

    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.q_take |-> (head_reg != tail_reg))
        else $error("seed queue read while empty");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: rtl/dpl_ctrl.sv
// dpl_ctrl: sequencer for loading, clustering with seed queue expansion and label output
// uses dpl_pkg command and status bundles
`default_nettype none

module dpl_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire dpl_pkg::status_t st,
    output dpl_pkg::cmd_t         cmd
);

    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_FILL      = 4'd1;
    localparam logic [3:0] S_START     = 4'd2;
    localparam logic [3:0] S_OUTER     = 4'd3;
    localparam logic [3:0] S_CORE_J    = 4'd4;
    localparam logic [3:0] S_CORE_WAIT = 4'd5;
    localparam logic [3:0] S_CORE_END  = 4'd6;
    localparam logic [3:0] S_ENQ_J     = 4'd7;
    localparam logic [3:0] S_ENQ_WAIT  = 4'd8;
    localparam logic [3:0] S_DRAIN     = 4'd9;
    localparam logic [3:0] S_DRAIN_W   = 4'd10;
    localparam logic [3:0] S_DRAIN_X   = 4'd11;
    localparam logic [3:0] S_EMIT_RD   = 4'd12;
    localparam logic [3:0] S_EMIT_W    = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       from_q_reg, from_q_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            from_q_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            from_q_reg <= from_q_next;
        end
    end

    assign in_ready = state_reg == S_LOAD;

    always_comb
    begin
        state_next  = state_reg;
        from_q_next = from_q_reg;
        cmd         = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.load = in_valid;
                if (in_valid && st.set_last)
                begin
                    state_next = st.fill_needed ? S_FILL : S_START;
                end
            end
            S_FILL:
            begin
                // zero the features a short final point never got
                cmd.fill_step = 1'b1;
                if (st.fill_last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.clu_start = 1'b1;
                state_next    = S_OUTER;
            end
            S_OUTER:
            begin
                if (st.i_end)
                begin
                    cmd.j_clear = 1'b1;
                    state_next  = S_EMIT_RD;
                end
                else if (st.i_visited)
                begin
                    cmd.i_inc = 1'b1;
                end
                else
                begin
                    cmd.core_from_i = 1'b1;
                    from_q_next     = 1'b0;
                    state_next      = S_CORE_J;
                end
            end
            S_CORE_J:
            begin
                if (st.j_end)
                begin
                    state_next = S_CORE_END;
                end
                else
                begin
                    cmd.pair_start = 1'b1;
                    state_next     = S_CORE_WAIT;
                end
            end
            S_CORE_WAIT:
            begin
                if (st.pair_done)
                begin
                    cmd.cnt_inc = st.neighbor;
                    cmd.j_inc   = 1'b1;
                    state_next  = S_CORE_J;
                end
            end
            S_CORE_END:
            begin
                if (from_q_reg)
                begin
                    cmd.j_clear = st.is_core;
                    state_next  = st.is_core ? S_ENQ_J : S_DRAIN;
                end
                else if (!st.is_core)
                begin
                    cmd.mark_noise = 1'b1;
                    cmd.i_inc      = 1'b1;
                    state_next     = S_OUTER;
                end
                else
                begin
                    // new cluster seeded from point i
                    cmd.mark_cluster = 1'b1;
                    cmd.seed_i       = 1'b1;
                    cmd.j_clear      = 1'b1;
                    state_next       = S_ENQ_J;
                end
            end
            S_ENQ_J:
            begin
                if (st.j_end)
                begin
                    state_next = S_DRAIN;
                end
                else if (st.j_skip)
                begin
                    cmd.j_inc = 1'b1;
                end
                else
                begin
                    cmd.pair_start = 1'b1;
                    state_next     = S_ENQ_WAIT;
                end
            end
            S_ENQ_WAIT:
            begin
                if (st.pair_done)
                begin
                    cmd.push_j = st.neighbor;
                    cmd.j_inc  = 1'b1;
                    state_next = S_ENQ_J;
                end
            end
            S_DRAIN:
            begin
                if (st.q_empty)
                begin
                    cmd.cluster_inc = 1'b1;
                    cmd.i_inc       = 1'b1;
                    state_next      = S_OUTER;
                end
                else
                begin
                    state_next = S_DRAIN_W;
                end
            end
            S_DRAIN_W:
            begin
                cmd.q_take = 1'b1;
                state_next = S_DRAIN_X;
            end
            S_DRAIN_X:
            begin
                cmd.mark_sel_q = 1'b1;
                if (st.q_visited && st.q_noise)
                begin
                    // noise point becomes a border point
                    cmd.mark_cluster = 1'b1;
                    state_next       = S_DRAIN;
                end
                else if (!st.q_visited)
                begin
                    cmd.mark_cluster = 1'b1;
                    cmd.core_from_q  = 1'b1;
                    from_q_next      = 1'b1;
                    state_next       = S_CORE_J;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_EMIT_RD:
            begin
                if (st.j_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_LOAD;
                end
                else if (!st.out_busy)
                begin
                    state_next = S_EMIT_W;
                end
            end
            S_EMIT_W:
            begin
                cmd.out_load = 1'b1;
                cmd.j_inc    = 1'b1;
                state_next   = S_EMIT_RD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_LOAD && in_valid))
        else $error("feature taken outside load");

    a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CORE_WAIT || state_reg == S_ENQ_WAIT) && !st.pair_done)
        |=> (state_reg == $past(state_reg)))
        else $error("left pair wait before distance done");

    a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_W) |-> ($past(state_reg) == S_EMIT_RD))
        else $error("result loaded without label read");

endmodule

`default_nettype wire
